// ===== rtl/core/min_tracking_stack_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the min tracking stack
// Shared property shapes used by the port checker.
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_TOP_DEFINES_SVH
`define MIN_TRACKING_STACK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MTS_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("min tracking stack check failed");

// Next-cycle implication, disabled during reset.
`define MTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("min tracking stack check failed");

`endif

// ===== rtl/core/mts_pkg.sv =====
// ---------------------------------------------------------------------------
// mts_pkg
// Constants, codes and controller/datapath link types for the min stack.
// ---------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the operation
    logic exec;     // perform push or pop
    logic load;     // refill cached tops from memory read data
    logic report;   // register the result fields
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_pop;
  } dp_stat_t;

endpackage

// ===== rtl/core/min_tracking_stack_top.sv =====
// ---------------------------------------------------------------------------
// min_tracking_stack_top
// Signed 32-bit LIFO stack that reports its running minimum.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind (0 push, 1 pop) and push_value with start
//   high; the transfer happens on a rising edge with start high and busy
//   low. busy stays high until the result is presented.
//   Result channel: done pulses for exactly one cycle with top_value,
//   min_value, is_empty and status valid in that cycle. The receiver
//   cannot stall, so each result must be taken in its done cycle.
//   After its transfer edge a push steps through the execute and report
//   states, and done rises when report ends; a pop also steps through the
//   load state between the two. The load state applies the registered read
//   of the value and minimum stores to the cached tops. A new command can
//   be taken in the done cycle, but not before it.
//   Push on a full stack returns status overflow and changes nothing;
//   pop on an empty stack returns status underflow and changes nothing.
//   Reset (rst, synchronous, active high) empties both stacks, drops any
//   operation in flight and clears busy and done. Store contents are not
//   cleared; only entries below the counts affect the results.
// ---------------------------------------------------------------------------
module min_tracking_stack_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic signed [mts_pkg::DATA_W-1:0] push_value,
  output logic                              done,
  output logic signed [mts_pkg::DATA_W-1:0] top_value,
  output logic signed [mts_pkg::DATA_W-1:0] min_value,
  output logic                              is_empty,
  output logic [1:0]                        status
);
  import mts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each operation.
  mts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the stacks and register the result fields.
  mts_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .push_value (push_value),
    .top_value  (top_value),
    .min_value  (min_value),
    .is_empty   (is_empty),
    .status     (status)
  );

endmodule

// ===== rtl/core/mts_ctrl.sv =====
// ---------------------------------------------------------------------------
// mts_ctrl
// Sequencer for one stack operation: capture, execute, refill (pops only), report.
// ---------------------------------------------------------------------------
module mts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mts_pkg::dp_stat_t stat,
  output mts_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             done
);
  import mts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_REPORT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        if (start && !busy) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.op_pop ? ST_LOAD : ST_REPORT;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
      done  <= cmd.report;
    end
  end

endmodule

// ===== rtl/core/mts_datapath.sv =====
// ---------------------------------------------------------------------------
// mts_datapath
// Value and minimum stores, counts, cached tops and result registers.
// ---------------------------------------------------------------------------
module mts_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mts_pkg::dp_cmd_t                  cmd,
  output mts_pkg::dp_stat_t                 stat,
  input  logic                              kind,
  input  logic signed [mts_pkg::DATA_W-1:0] push_value,
  output logic signed [mts_pkg::DATA_W-1:0] top_value,
  output logic signed [mts_pkg::DATA_W-1:0] min_value,
  output logic                              is_empty,
  output logic [1:0]                        status
);
  import mts_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT   = CNT_W'(2);

  logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] min_mem   [STACK_DEPTH];

  logic                     op_kind;
  logic signed [DATA_W-1:0] op_value;
  logic [CNT_W-1:0]         value_count;
  logic [CNT_W-1:0]         min_count;
  logic signed [DATA_W-1:0] top_reg;
  logic signed [DATA_W-1:0] min_top;
  logic [1:0]               status_reg;
  logic signed [DATA_W-1:0] rd_value;
  logic signed [DATA_W-1:0] rd_min;

  logic             is_full;
  logic             is_zero;
  logic             do_push;
  logic             push_min;
  logic             do_pop;
  logic             pop_min;
  logic [CNT_W-1:0] value_rd_cnt;
  logic [CNT_W-1:0] min_rd_cnt;

  assign stat.op_pop = (op_kind == KIND_POP);

  assign is_full  = (value_count == DEPTH_CNT);
  assign is_zero  = (value_count == '0);
  assign do_push  = cmd.exec && (op_kind == KIND_PUSH) && !is_full;
  assign push_min = do_push && (min_count != DEPTH_CNT)
                    && ((min_count == '0) || (op_value <= min_top));
  assign do_pop   = cmd.exec && (op_kind == KIND_POP) && !is_zero;
  assign pop_min  = do_pop && (min_count != '0) && (top_reg == min_top);

  // Address of the new tops after a pop.
  assign value_rd_cnt = value_count - TWO_CNT;
  assign min_rd_cnt   = pop_min ? (min_count - TWO_CNT) : (min_count - ONE_CNT);

  always_ff @(posedge clk) begin
    if (do_push) begin
      value_mem[value_count[ADDR_W-1:0]] <= op_value;
    end
    if (push_min) begin
      min_mem[min_count[ADDR_W-1:0]] <= op_value;
    end
    rd_value <= value_mem[value_rd_cnt[ADDR_W-1:0]];
    rd_min   <= min_mem[min_rd_cnt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      min_count   <= '0;
    end else begin
      if (do_push) begin
        value_count <= value_count + ONE_CNT;
      end else if (do_pop) begin
        value_count <= value_count - ONE_CNT;
      end
      if (push_min) begin
        min_count <= min_count + ONE_CNT;
      end else if (pop_min) begin
        min_count <= min_count - ONE_CNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind  <= kind;
      op_value <= push_value;
    end
    if (cmd.exec) begin
      if (op_kind == KIND_PUSH) begin
        status_reg <= is_full ? STATUS_OVERFLOW : STATUS_OK;
      end else begin
        status_reg <= is_zero ? STATUS_UNDERFLOW : STATUS_OK;
      end
    end
    if (do_push) begin
      top_reg <= op_value;
    end
    if (push_min) begin
      min_top <= op_value;
    end
    if (cmd.load) begin
      top_reg <= rd_value;
      min_top <= rd_min;
    end
    if (cmd.report) begin
      top_value <= is_zero ? '0 : top_reg;
      min_value <= (is_zero || (min_count == '0)) ? '0 : min_top;
      is_empty  <= is_zero;
      status    <= status_reg;
    end
  end

endmodule

// ===== rtl/core/mts_checker.sv =====
// ---------------------------------------------------------------------------
// mts_checker
// Port-level checks for the min tracking stack, bound to the top level.
// ---------------------------------------------------------------------------
`include "min_tracking_stack_top_defines.svh"

module mts_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [mts_pkg::DATA_W-1:0] top_value,
  input logic signed [mts_pkg::DATA_W-1:0] min_value,
  input logic                              is_empty,
  input logic [1:0]                        status
);
  import mts_pkg::*;

  `MTS_ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy && !done)
  `MTS_ASSERT_IMPLIES(a_done_frees, clk, rst, done, !busy)
  `MTS_ASSERT_IMPLIES(a_empty_zero, clk, rst, done && is_empty, (top_value == '0) && (min_value == '0))
  `MTS_ASSERT_IMPLIES(a_underflow_empty, clk, rst, done && (status == STATUS_UNDERFLOW), is_empty)
  `MTS_ASSERT_IMPLIES(a_min_le_top, clk, rst, done && !is_empty, min_value <= top_value)

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .top_value (top_value),
  .min_value (min_value),
  .is_empty  (is_empty),
  .status    (status)
);
